/* hw/rtl/zmr_pkg.sv */
// Shared types, register indexes and the threshold decision helper
// for the z-score mean-reversion signal. No dependencies.
package zmr_pkg;

  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_SYMBOL_SEL = 3'd1;
  localparam logic [2:0] REG_LOOKBACK   = 3'd2;
  localparam logic [2:0] REG_ENTRY_LVL  = 3'd3;
  localparam logic [2:0] REG_EXIT_LVL   = 3'd4;
  localparam logic [2:0] REG_POS_LIMIT  = 3'd5;
  localparam logic [2:0] REG_ENTRY_SIZE = 3'd6;

  localparam logic [1:0] HOLD_FLAT  = 2'd0;
  localparam logic [1:0] HOLD_LONG  = 2'd1;
  localparam logic [1:0] HOLD_SHORT = 2'd2;

  localparam int LEVEL_BITS = 16;
  localparam int LSQ_BITS   = 31;

  typedef struct packed {
    logic capture;
    logic load;
    logic update;
    logic prod;
    logic diff;
    logic mul_en;
    logic mul_exit;
    logic cmp_entry;
    logic cmp_exit;
    logic decide;
    logic out_second;
  } cmd_t;

  typedef struct packed {
    logic       pass;
    logic       full_next;
    logic [1:0] dec_count;
    logic       two;
  } status_t;

  typedef struct packed {
    logic        side;
    logic [23:0] price;
    logic [31:0] qty;
    logic        is_exit;
  } order_t;

  // Returns {greater, less} for z against a signed level, given the sign of
  // z, the magnitude comparison of the squared sides and a zero-variance flag.
  function automatic logic [1:0] zcmp(input logic dz, input logic neg,
                                      input logic mz, input logic lneg,
                                      input logic lzero, input logic cgt,
                                      input logic clt);
    logic [1:0] r;
    logic sxpos, sxneg, sypos, syneg;
    sxpos = !mz && !neg;
    sxneg = !mz && neg;
    sypos = !lzero && !lneg;
    syneg = !lzero && lneg;
    if (dz) begin
      r = lzero ? 2'b00 : (lneg ? 2'b10 : 2'b01);
    end else if ((sxpos != sypos) || (sxneg != syneg)) begin
      r = ((sxpos && !sypos) || (!sxpos && !sxneg && syneg)) ? 2'b10 : 2'b01;
    end else if (mz) begin
      r = 2'b00;
    end else begin
      r = sxpos ? {cgt, clt} : {clt, cgt};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/zscore_mean_reversion_signal.sv */
// Rolling z-score mean-reversion signal: a tick whose window is full gives
// its first order, if any, after the load, update, product, difference,
// entry multiply, exit multiply, exit compare and decide steps, and a second
// one, if the decision made two, once the first is taken. One tick at a time,
// set by the shared multiplier pair and single memory port. Reset restores
// register defaults, empties window counters, goes flat; window memory stays.
module zscore_mean_reversion_signal #(
  parameter int WINDOW_MAX = 256,
  parameter int PRICE_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        symbol_id,
  input  logic [23:0]        mid_px,
  input  logic [23:0]        bid_price,
  input  logic [23:0]        ask_price,
  input  logic signed [31:0] net_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               order_side,
  output logic [23:0]        order_price,
  output logic [31:0]        order_qty,
  output logic               is_exit,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  zmr_pkg::cmd_t    cmd;
  zmr_pkg::status_t status;

  assign cfg_ready = 1'b1;

  zmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  zmr_datapath #(
    .WINDOW_MAX (WINDOW_MAX),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .symbol_id    (symbol_id),
    .mid_px       (mid_px),
    .bid_price    (bid_price),
    .ask_price    (ask_price),
    .net_position (net_position),
    .order_side   (order_side),
    .order_price  (order_price),
    .order_qty    (order_qty),
    .is_exit      (is_exit),
    .last         (last)
  );

  // No new item is taken while a result waits.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

endmodule

/* hw/rtl/zmr_ctrl.sv */
// Sequencing state machine for the z-score signal block.
// Depends on zmr_pkg for the command and status structs.
module zmr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output zmr_pkg::cmd_t    cmd,
  input  zmr_pkg::status_t status
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LOAD   = 4'd1;
  localparam logic [3:0] ST_UPDATE = 4'd2;
  localparam logic [3:0] ST_PROD   = 4'd3;
  localparam logic [3:0] ST_DIFF   = 4'd4;
  localparam logic [3:0] ST_MULE   = 4'd5;
  localparam logic [3:0] ST_MULX   = 4'd6;
  localparam logic [3:0] ST_CMPX   = 4'd7;
  localparam logic [3:0] ST_DECIDE = 4'd8;
  localparam logic [3:0] ST_OUT0   = 4'd9;
  localparam logic [3:0] ST_OUT1   = 4'd10;

  logic [3:0] state, state_next;
  logic       in_accept;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT0) || (state == ST_OUT1);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    cmd.capture    = in_accept;
    cmd.load       = (state == ST_LOAD);
    cmd.update     = (state == ST_UPDATE);
    cmd.prod       = (state == ST_PROD);
    cmd.diff       = (state == ST_DIFF);
    cmd.mul_en     = (state == ST_MULE) || (state == ST_MULX);
    cmd.mul_exit   = (state == ST_MULX);
    cmd.cmp_entry  = (state == ST_MULX);
    cmd.cmp_exit   = (state == ST_CMPX);
    cmd.decide     = (state == ST_DECIDE);
    cmd.out_second = (state == ST_OUT1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_accept && status.pass) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = status.full_next ? ST_PROD : ST_IDLE;
      ST_PROD:   state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_MULE;
      ST_MULE:   state_next = ST_MULX;
      ST_MULX:   state_next = ST_CMPX;
      ST_CMPX:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = (status.dec_count == 2'd0) ? ST_IDLE : ST_OUT0;
      ST_OUT0: begin
        if (!out_stall) state_next = status.two ? ST_OUT1 : ST_IDLE;
      end
      ST_OUT1:   if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Results appear only after a decision.
  a_out_after_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DECIDE))
    else $error("result shown without a decision");

  // The second result slot is used only when the decision produced two.
  a_second_needs_two: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT1) |-> status.two)
    else $error("second result without a two-result decision");

endmodule

/* hw/rtl/zmr_datapath.sv */
// Window memory, running sums, exact z-score threshold arithmetic and the
// position machine. Depends on zmr_pkg; sequenced by zmr_ctrl.
module zmr_datapath #(
  parameter int WINDOW_MAX = 256,
  parameter int PRICE_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  zmr_pkg::cmd_t      cmd,
  output zmr_pkg::status_t   status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [15:0]        symbol_id,
  input  logic [23:0]        mid_px,
  input  logic [23:0]        bid_price,
  input  logic [23:0]        ask_price,
  input  logic signed [31:0] net_position,
  output logic               order_side,
  output logic [23:0]        order_price,
  output logic [31:0]        order_qty,
  output logic               is_exit,
  output logic               last
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NW = $clog2(WINDOW_MAX + 1);
  localparam int SW = PRICE_BITS + AW;
  localparam int QW = 2 * PRICE_BITS + AW;
  localparam int DW = 2 * SW;
  localparam int PW = SW + zmr_pkg::LSQ_BITS;
  localparam int CW = 2 * SW + zmr_pkg::LSQ_BITS;

  // Configuration registers.
  logic              enable;
  logic [15:0]       symbol_sel;
  logic [8:0]        lookback;
  logic signed [15:0] entry_level;
  logic signed [15:0] exit_level;
  logic [30:0]       position_limit;
  logic [31:0]       entry_size;

  // Captured tick.
  logic [PRICE_BITS-1:0] p_r;
  logic [23:0]           bid_r, ask_r;
  logic signed [31:0]    pos_r;

  // Window state.
  logic [PRICE_BITS-1:0] mem [WINDOW_MAX];
  logic [PRICE_BITS-1:0] mem_rd;
  logic [AW-1:0]         write_slot, slot_r;
  logic [NW-1:0]         fill_count;
  logic [SW-1:0]         window_sum;
  logic [QW-1:0]         square_sum;
  logic [1:0]            holding;

  // Arithmetic pipeline registers.
  logic [2*PRICE_BITS-1:0] pp;
  logic [SW-1:0]           np, mag;
  logic                    neg;
  logic [DW-1:0]           nq, ss, d, mm;
  logic [zmr_pkg::LSQ_BITS-1:0] l2e, l2x;
  logic [PW-1:0]           pl, ph;
  logic                    ce_gt, ce_lt, cx_gt, cx_lt;
  logic [1:0]              rcnt;
  zmr_pkg::order_t         res0, res1;

  logic [NW-1:0]         n;
  logic [PRICE_BITS-1:0] p_in;
  logic [AW-1:0]         slot;
  logic                  full;
  logic [NW-1:0]         fill_inc, ws_inc;
  logic [QW-1:0]         oldsq;
  logic [15:0]           le_mag, lx_mag;
  logic [zmr_pkg::LSQ_BITS-1:0] l2_sel;
  logic [CW-1:0]         rval, mval;
  logic                  lookback_wr;

  always_comb begin
    if (lookback < 9'd2) begin
      n = NW'(2);
    end else if (int'(lookback) > WINDOW_MAX) begin
      n = NW'(WINDOW_MAX);
    end else begin
      n = NW'(lookback);
    end
  end

  assign p_in        = PRICE_BITS'(mid_px);
  assign status.pass = enable && (symbol_id == symbol_sel) && (p_in != '0);
  assign slot        = (NW'(write_slot) < n) ? write_slot : '0;
  assign full        = (fill_count >= n);
  assign fill_inc    = fill_count + NW'(1);
  assign ws_inc      = NW'(slot_r) + NW'(1);
  assign oldsq       = QW'(mem_rd) * QW'(mem_rd);
  assign status.full_next = full || (fill_inc >= n);
  assign lookback_wr = cfg_we && (cfg_index == zmr_pkg::REG_LOOKBACK);

  assign le_mag = entry_level[15] ? 16'(-entry_level) : 16'(entry_level);
  assign lx_mag = exit_level[15] ? 16'(-exit_level) : 16'(exit_level);
  assign l2_sel = cmd.mul_exit ? l2x : l2e;
  assign rval   = (CW'(ph) << SW) + CW'(pl);
  assign mval   = CW'(mm) << 16;

  // Config registers: user writes only while the block is idle; unenforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      symbol_sel     <= '0;
      lookback       <= 9'd20;
      entry_level    <= 16'sd512;
      exit_level     <= 16'sd128;
      position_limit <= 31'd1000;
      entry_size     <= 32'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        zmr_pkg::REG_ENABLE:     enable <= cfg_data[0];
        zmr_pkg::REG_SYMBOL_SEL: symbol_sel <= cfg_data[15:0];
        zmr_pkg::REG_LOOKBACK:   lookback <= cfg_data[8:0];
        zmr_pkg::REG_ENTRY_LVL:  entry_level <= $signed(cfg_data[15:0]);
        zmr_pkg::REG_EXIT_LVL:   exit_level <= $signed(cfg_data[15:0]);
        zmr_pkg::REG_POS_LIMIT:  position_limit <= cfg_data[30:0];
        zmr_pkg::REG_ENTRY_SIZE: entry_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window memory: one read in the load step, one write in the update step.
  always_ff @(posedge clk) begin
    if (cmd.load) mem_rd <= mem[slot];
    if (cmd.update) mem[slot_r] <= p_r;
  end

  // Window counters and running sums.
  always_ff @(posedge clk) begin
    if (rst || lookback_wr) begin
      write_slot <= '0;
      fill_count <= '0;
      window_sum <= '0;
      square_sum <= '0;
    end else if (cmd.update) begin
      window_sum <= window_sum + SW'(p_r) - (full ? SW'(mem_rd) : '0);
      square_sum <= square_sum + QW'(pp) - (full ? oldsq : '0);
      write_slot <= (ws_inc == n) ? '0 : AW'(ws_inc);
      if (!full) fill_count <= fill_inc;
    end
  end

  // Arithmetic steps, each with its product registered.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p_r   <= p_in;
      bid_r <= bid_price;
      ask_r <= ask_price;
      pos_r <= net_position;
    end
    if (cmd.load) begin
      slot_r <= slot;
      pp     <= (2*PRICE_BITS)'(p_r) * (2*PRICE_BITS)'(p_r);
      np     <= SW'(n) * SW'(p_r);
    end
    if (cmd.prod) begin
      nq  <= DW'(n) * DW'(square_sum);
      ss  <= DW'(window_sum) * DW'(window_sum);
      neg <= (np < window_sum);
      mag <= (np < window_sum) ? window_sum - np : np - window_sum;
      l2e <= zmr_pkg::LSQ_BITS'(le_mag) * zmr_pkg::LSQ_BITS'(le_mag);
      l2x <= zmr_pkg::LSQ_BITS'(lx_mag) * zmr_pkg::LSQ_BITS'(lx_mag);
    end
    if (cmd.diff) begin
      d  <= nq - ss;
      mm <= DW'(mag) * DW'(mag);
    end
    // The variance is scaled by a squared level in two half-width products.
    if (cmd.mul_en) begin
      pl <= PW'(d[SW-1:0]) * PW'(l2_sel);
      ph <= PW'(d[DW-1:SW]) * PW'(l2_sel);
    end
    if (cmd.cmp_entry) begin
      ce_gt <= (mval > rval);
      ce_lt <= (mval < rval);
    end
    if (cmd.cmp_exit) begin
      cx_gt <= (mval > rval);
      cx_lt <= (mval < rval);
    end
  end

  // Position machine decision.
  logic        dz, mz, e_lz, x_lz, e_nneg, x_nneg;
  logic [1:0]  ze, zne, zx, znx;
  logic signed [32:0] pos_x, lim_x;
  logic        above, below, have_ex;
  logic [31:0] absq;
  logic [1:0]  h, cnt;
  zmr_pkg::order_t r0, r1, ex;

  always_comb begin
    dz     = (d == '0);
    mz     = (mag == '0);
    e_lz   = (entry_level == '0);
    x_lz   = (exit_level == '0);
    e_nneg = !entry_level[15] && !e_lz;
    x_nneg = !exit_level[15] && !x_lz;
    ze  = zmr_pkg::zcmp(dz, neg, mz, entry_level[15], e_lz, ce_gt, ce_lt);
    zne = zmr_pkg::zcmp(dz, neg, mz, e_nneg, e_lz, ce_gt, ce_lt);
    zx  = zmr_pkg::zcmp(dz, neg, mz, exit_level[15], x_lz, cx_gt, cx_lt);
    znx = zmr_pkg::zcmp(dz, neg, mz, x_nneg, x_lz, cx_gt, cx_lt);
    pos_x = {pos_r[31], pos_r};
    lim_x = $signed({2'b00, position_limit});
    above = pos_x > -lim_x;
    below = pos_x < lim_x;
    absq  = pos_r[31] ? 32'(-pos_r) : 32'(pos_r);

    h       = holding;
    cnt     = 2'd0;
    r0      = '0;
    r1      = '0;
    ex      = '0;
    have_ex = 1'b0;
    if (h == zmr_pkg::HOLD_FLAT) begin
      if (ze[1] && above) begin
        r0.side = 1'b1;
        r0.price = bid_r;
        r0.qty = entry_size;
        cnt = 2'd1;
        h = zmr_pkg::HOLD_SHORT;
      end else if (zne[0] && below) begin
        r0.side = 1'b0;
        r0.price = ask_r;
        r0.qty = entry_size;
        cnt = 2'd1;
        h = zmr_pkg::HOLD_LONG;
      end
    end
    if (h == zmr_pkg::HOLD_SHORT && zx[0]) begin
      ex.side = 1'b0;
      ex.price = ask_r;
      have_ex = 1'b1;
    end else if (h == zmr_pkg::HOLD_LONG && znx[1]) begin
      ex.side = 1'b1;
      ex.price = bid_r;
      have_ex = 1'b1;
    end
    ex.qty = absq;
    ex.is_exit = 1'b1;
    if (have_ex) begin
      h = zmr_pkg::HOLD_FLAT;
      if (cnt == 2'd0) begin
        r0 = ex;
      end else begin
        r1 = ex;
      end
      cnt = cnt + 2'd1;
    end
  end

  assign status.dec_count = cnt;
  assign status.two       = (rcnt == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      holding <= zmr_pkg::HOLD_FLAT;
      rcnt    <= 2'd0;
    end else if (cmd.decide) begin
      holding <= h;
      rcnt    <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res0 <= r0;
      res1 <= r1;
    end
  end

  zmr_pkg::order_t sel;
  assign sel         = cmd.out_second ? res1 : res0;
  assign order_side  = sel.side;
  assign order_price = sel.price;
  assign order_qty   = sel.qty;
  assign is_exit     = sel.is_exit;
  assign last        = cmd.out_second || (rcnt == 2'd1);

  // Writing the window length empties the window.
  a_lookback_clears: assert property (@(posedge clk) disable iff (rst)
    lookback_wr |=> (fill_count == '0) && (window_sum == '0))
    else $error("window not emptied by a length write");

  // A tick that still fills the window leaves the position machine alone.
  a_fill_no_decide: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && !status.full_next) |=> $stable(holding))
    else $error("position changed while the window was filling");

endmodule

/* test/tb_zscore_mean_reversion_signal.sv */
// Testbench for the rolling z-score mean-reversion signal block.
// Drives ticks and register writes, predicts orders with its own window model.
// Depends on zmr_pkg and zscore_mean_reversion_signal.
`timescale 1ns / 1ps

module tb_zscore_mean_reversion_signal;

  // Index past the last register; writes to it must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        symbol_id;
  logic [23:0]        mid_px;
  logic [23:0]        bid_price;
  logic [23:0]        ask_price;
  logic signed [31:0] net_position;
  logic               out_valid;
  logic               out_stall;
  logic               order_side;
  logic [23:0]        order_price;
  logic [31:0]        order_qty;
  logic               is_exit;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  zscore_mean_reversion_signal u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .symbol_id(symbol_id), .mid_px(mid_px), .bid_price(bid_price),
    .ask_price(ask_price), .net_position(net_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .order_side(order_side), .order_price(order_price), .order_qty(order_qty),
    .is_exit(is_exit), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic        side;
    logic [23:0] price;
    logic [31:0] qty;
    logic        exit_flag;
    logic        fin;
  } order_exp_t;

  // Predictor state.
  logic               sig_enable;
  logic [15:0]        sig_symbol;
  logic [8:0]         sig_lookback;
  logic signed [15:0] sig_entry;
  logic signed [15:0] sig_exit;
  logic [30:0]        sig_limit;
  logic [31:0]        sig_size;
  logic [23:0]        prices [256];
  int unsigned        slot_ptr;
  int unsigned        filled;
  logic [63:0]        price_sum;
  logic [127:0]       price_sq_sum;
  logic [1:0]         position_state;

  order_exp_t pending_orders[$];
  int  errors;
  int  idle_pct;
  int  stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned window_len();
    int unsigned n;
    n = sig_lookback;
    if (n < 2) n = 2;
    if (n > 256) n = 256;
    return n;
  endfunction

  // Sign of z minus level/256, decided on squared sides.
  function automatic int z_vs_level(bit neg, logic [63:0] mag, logic [127:0] dvar,
                                    int lvl);
    int sx, sy;
    logic [127:0] lhs, rhs, lm;
    if (dvar == 0) return lvl > 0 ? -1 : (lvl < 0 ? 1 : 0);
    sx = (mag == 0) ? 0 : (neg ? -1 : 1);
    sy = (lvl == 0) ? 0 : (lvl < 0 ? -1 : 1);
    if (sx != sy) return sx > sy ? 1 : -1;
    if (sx == 0) return 0;
    lm = (lvl < 0) ? -lvl : lvl;
    lhs = (128'(mag) << 8) * (128'(mag) << 8);
    rhs = dvar * (lm * lm);
    if (lhs == rhs) return 0;
    return (lhs > rhs) == (sx > 0) ? 1 : -1;
  endfunction

  function automatic void clear_window();
    slot_ptr = 0;
    filled = 0;
    price_sum = 0;
    price_sq_sum = 0;
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      zmr_pkg::REG_ENABLE:     sig_enable = val[0];
      zmr_pkg::REG_SYMBOL_SEL: sig_symbol = val[15:0];
      zmr_pkg::REG_LOOKBACK:   begin sig_lookback = val[8:0]; clear_window(); end
      zmr_pkg::REG_ENTRY_LVL:  sig_entry = val[15:0];
      zmr_pkg::REG_EXIT_LVL:   sig_exit = val[15:0];
      zmr_pkg::REG_POS_LIMIT:  sig_limit = val[30:0];
      zmr_pkg::REG_ENTRY_SIZE: sig_size = val;
      default: ;
    endcase
  endfunction

  function automatic void push_order(logic sd, logic [23:0] pr, logic [31:0] q,
                                     logic ex);
    order_exp_t o;
    o.side = sd; o.price = pr; o.qty = q; o.exit_flag = ex; o.fin = 1'b0;
    pending_orders.insert(pending_orders.size(), o);
  endfunction

  function automatic void predict_orders(logic [15:0] sym, logic [23:0] mid,
                                         logic [23:0] bid, logic [23:0] ask,
                                         logic signed [31:0] pos);
    int unsigned n, slot, made;
    logic [23:0] old;
    logic [63:0] np, mag;
    logic [127:0] dvar;
    bit neg;
    longint p64, lim;
    logic [31:0] absq;
    n = window_len();
    if (!sig_enable || sym != sig_symbol || mid == 0) return;
    slot = (slot_ptr < n) ? slot_ptr : 0;
    if (filled >= n) begin
      old = prices[slot];
      price_sum -= old;
      price_sq_sum -= 128'(old) * 128'(old);
    end
    prices[slot] = mid;
    price_sum += mid;
    price_sq_sum += 128'(mid) * 128'(mid);
    slot_ptr = (slot + 1) % n;
    if (filled < n) filled++;
    if (filled < n) return;
    np = 64'(n) * mid;
    neg = np < price_sum;
    mag = neg ? price_sum - np : np - price_sum;
    dvar = price_sq_sum * n - 128'(price_sum) * 128'(price_sum);
    p64 = pos;
    lim = sig_limit;
    absq = (pos < 0) ? -pos : pos;
    made = 0;
    if (position_state == zmr_pkg::HOLD_FLAT) begin
      if (z_vs_level(neg, mag, dvar, sig_entry) > 0 && p64 > -lim) begin
        push_order(1'b1, bid, sig_size, 1'b0);
        position_state = zmr_pkg::HOLD_SHORT;
        made++;
      end else if (z_vs_level(neg, mag, dvar, -int'(sig_entry)) < 0 && p64 < lim) begin
        push_order(1'b0, ask, sig_size, 1'b0);
        position_state = zmr_pkg::HOLD_LONG;
        made++;
      end
    end
    if (position_state == zmr_pkg::HOLD_SHORT &&
        z_vs_level(neg, mag, dvar, sig_exit) < 0) begin
      push_order(1'b0, ask, absq, 1'b1);
      position_state = zmr_pkg::HOLD_FLAT;
      made++;
    end else if (position_state == zmr_pkg::HOLD_LONG &&
                 z_vs_level(neg, mag, dvar, -int'(sig_exit)) > 0) begin
      push_order(1'b1, bid, absq, 1'b1);
      position_state = zmr_pkg::HOLD_FLAT;
      made++;
    end
    if (made > 0) pending_orders[$].fin = 1'b1;
  endfunction

  // Receiver: random stall and order check.
  always @(posedge clk) begin
    order_exp_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_orders.size() == 0) begin
          $display("%0t: unexpected order side=%0d price=%0d qty=%0d exit=%0d last=%0d",
                   $time, order_side, order_price, order_qty, is_exit, last);
          errors++;
        end else begin
          e = pending_orders[0];
          pending_orders.delete(0);
          if (order_side !== e.side || order_price !== e.price || order_qty !== e.qty ||
              is_exit !== e.exit_flag || last !== e.fin) begin
            $display("%0t: order mismatch expected side=%0d price=%0d qty=%0d exit=%0d last=%0d actual side=%0d price=%0d qty=%0d exit=%0d last=%0d",
                     $time, e.side, e.price, e.qty, e.exit_flag, e.fin,
                     order_side, order_price, order_qty, is_exit, last);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Valid stays up after the accepting edge until the caller moves on; the
  // next item or another task takes it from there.
  task automatic send_tick(logic [15:0] sym, logic [23:0] mid, logic [23:0] bid,
                           logic [23:0] ask, logic signed [31:0] pos);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol_id <= sym;
    mid_px <= mid;
    bid_price <= bid;
    ask_price <= ask;
    net_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_orders(sym, mid, bid, ask, pos);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_orders.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 200000) begin
      $display("*** FAILED ***");
      $finish;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, val);
  endtask

  task automatic setup(logic [15:0] sym, int unsigned lb, int ent, int ext,
                       logic [30:0] lim, logic [31:0] sz);
    drain();
    write_reg(zmr_pkg::REG_ENABLE, 32'd1);
    write_reg(zmr_pkg::REG_SYMBOL_SEL, sym);
    write_reg(zmr_pkg::REG_LOOKBACK, lb);
    write_reg(zmr_pkg::REG_ENTRY_LVL, 32'(ent));
    write_reg(zmr_pkg::REG_EXIT_LVL, 32'(ext));
    write_reg(zmr_pkg::REG_POS_LIMIT, lim);
    write_reg(zmr_pkg::REG_ENTRY_SIZE, sz);
  endtask

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $signed($urandom_range(2000)) - 1000;
      1: return $signed($urandom());
      2: return 32'sh7FFFFFFF;
      default: return -32'sh7FFFFFFF;
    endcase
  endfunction

  // Mean-reverting prices with occasional jumps so that z crosses thresholds.
  task automatic run_random(int count, logic [15:0] sym, int unsigned base,
                            int unsigned spread);
    logic [23:0] mid;
    logic [15:0] s;
    for (int i = 0; i < count; i++) begin
      s = ($urandom_range(9) == 0) ? 16'($urandom()) : sym;
      if ($urandom_range(19) == 0) mid = 24'($urandom());
      else if ($urandom_range(29) == 0) mid = 0;
      else mid = 24'(base + $urandom_range(spread) * (($urandom_range(7) == 0) ? 8 : 1));
      if (mid == 0 && $urandom_range(1)) mid = 24'hFFFFFF;
      send_tick(s, mid, 24'($urandom()), 24'($urandom()), rand_pos());
    end
  endtask

  task automatic test_directed();
    setup(16'hFFFF, 2, 0, 0, 31'h7FFFFFFF, 32'hFFFFFFFF);
    send_tick(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 32'sh7FFFFFFF);
    send_tick(16'hFFFF, 24'h000001, 24'h000001, 24'hFFFFFF, -32'sh7FFFFFFF);
    // Zero variance window: z taken as zero.
    send_tick(16'hFFFF, 24'h000001, 24'h123456, 24'h654321, 32'sd5);
    send_tick(16'hFFFF, 24'hFFFFFF, 24'h111111, 24'h222222, 32'sd0);
    send_tick(16'hFFFF, 24'h000001, 24'h333333, 24'h444444, -32'sd7);
    // Ignored ticks: zero mid and wrong symbol.
    send_tick(16'hFFFF, 24'h000000, 24'h1, 24'h2, 32'sd1);
    send_tick(16'h0000, 24'h000100, 24'h1, 24'h2, 32'sd1);
    setup(16'h0000, 0, 32767, -32768, 31'd0, 32'd0);
    for (int i = 0; i < 6; i++)
      send_tick(16'h0000, 24'(1 + i * 1000), 24'(i), 24'(i + 9), 32'sd3);
    setup(16'h0000, 511, -32768, 32767, 31'd10, 32'd55);
    for (int i = 0; i < 8; i++)
      send_tick(16'h0000, 24'(100 + (i % 3)), 24'(i), 24'(i + 9), -32'sd20);
    drain();
    write_reg(zmr_pkg::REG_ENABLE, 32'd0);
    send_tick(16'h0000, 24'h100, 24'h1, 24'h2, 32'sd1);
  endtask

  task automatic test_random_phase(int unsigned lb, int ent, int ext, int count);
    setup(16'h00A5, lb, ent, ext, 31'($urandom_range(3000)), $urandom());
    run_random(count, 16'h00A5, 1000 + $urandom_range(100000), 50);
  endtask

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    symbol_id = '0;
    mid_px = '0;
    bid_price = '0;
    ask_price = '0;
    net_position = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sig_enable = 0; sig_symbol = 0; sig_lookback = 20; sig_entry = 512;
    sig_exit = 128; sig_limit = 1000; sig_size = 100;
    clear_window();
    position_state = zmr_pkg::HOLD_FLAT;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults after reset.
    write_reg(zmr_pkg::REG_ENABLE, 32'd1);
    for (int i = 0; i < 25; i++)
      send_tick(16'h0000, 24'(5000 + $urandom_range(40) * (i % 4 == 0 ? 10 : 1)),
                24'($urandom()), 24'($urandom()), rand_pos());
    test_directed();
    write_reg(REG_UNUSED, 32'hFFFFFFFF);

    idle_pct = 0;  stall_pct = 0;
    test_random_phase(4, 256, 64, 150);
    test_random_phase(2, 0, 0, 100);
    idle_pct = 87; stall_pct = 0;
    test_random_phase(8, 300, -100, 150);
    test_random_phase(256, 128, 32, 150);
    idle_pct = 0;  stall_pct = 87;
    test_random_phase(3, -50, 200, 150);
    test_random_phase(5, 200, 100, 150);
    idle_pct = 37; stall_pct = 37;
    test_random_phase(6, 150, 0, 150);
    test_random_phase(2, 32767, -32768, 50);

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
